// ===== rtl/rbfatc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbfatc_pkg
// Shared constants, codes and helper functions of the RBF adaptive torque
// controller.
// ----------------------------------------------------------------------------
package rbfatc_pkg;

  localparam int NODES           = 7;
  localparam int CENTER_STEP_Q16 = 32768;
  localparam int NODE_W          = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ADDR_W          = $clog2(2 * NODES);
  localparam int RAD_W           = 64;
  localparam int ROOT_W          = 32;
  localparam int ROOT_STEPS      = RAD_W / 2;
  localparam int STEP_W          = $clog2(ROOT_STEPS);

  typedef enum logic [2:0] {
    CFG_LAW     = 3'd0,
    CFG_FILTER  = 3'd1,
    CFG_KV      = 3'd2,
    CFG_ADAPT   = 3'd3,
    CFG_LEAK    = 3'd4,
    CFG_INV_WSQ = 3'd5,
    CFG_BOUND   = 3'd6,
    CFG_SOFT    = 3'd7
  } cfg_idx_t;

  localparam logic [2:0] LAW_PLAIN  = 3'd0;
  localparam logic [2:0] LAW_LEAK   = 3'd1;
  localparam logic [2:0] LAW_SMOOTH = 3'd2;
  localparam logic [2:0] LAW_SIGN   = 3'd3;
  localparam logic [2:0] LAW_PD     = 3'd4;

  typedef struct packed {
    logic              start;
    logic [RAD_W-1:0]  radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
    case (idx)
      5'd0:    return 17'd65536;
      5'd1:    return 17'd62757;
      5'd2:    return 17'd60097;
      5'd3:    return 17'd57549;
      5'd4:    return 17'd55109;
      5'd5:    return 17'd52773;
      5'd6:    return 17'd50535;
      5'd7:    return 17'd48393;
      5'd8:    return 17'd46341;
      5'd9:    return 17'd44376;
      5'd10:   return 17'd42495;
      5'd11:   return 17'd40693;
      5'd12:   return 17'd38968;
      5'd13:   return 17'd37316;
      5'd14:   return 17'd35734;
      5'd15:   return 17'd34219;
      default: return 17'd32768;
    endcase
  endfunction

  function automatic logic signed [31:0] center(input logic [NODE_W-1:0] j);
    int t;
    t = (2 * int'(j) - NODES + 1) * CENTER_STEP_Q16;
    return 32'(t >>> 1);
  endfunction

  function automatic logic signed [31:0] sat50(input logic signed [49:0] x);
    if (x > 50'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -50'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

// ===== rtl/rbfatc_isqrt.sv =====
// ----------------------------------------------------------------------------
// rbfatc_isqrt
// Bit-serial floor square root of a 64-bit radicand, two radicand bits per
// cycle, done pulse after the last step.
// ----------------------------------------------------------------------------
module rbfatc_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  rbfatc_pkg::sqrt_req_t  req,
  output rbfatc_pkg::sqrt_rsp_t  rsp
);

  logic [rbfatc_pkg::RAD_W-1:0]  rem;
  logic [rbfatc_pkg::RAD_W-1:0]  root;
  logic [rbfatc_pkg::RAD_W-1:0]  bitm;
  logic [rbfatc_pkg::STEP_W-1:0] cnt;
  logic                          busy;
  logic                          done;
  logic [rbfatc_pkg::RAD_W-1:0]  trial;

  assign trial = root + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start &&
              (cnt == rbfatc_pkg::STEP_W'(rbfatc_pkg::ROOT_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= req.radicand;
        root <= '0;
        bitm <= {2'b01, {(rbfatc_pkg::RAD_W-2){1'b0}}};
      end else if (busy) begin
        if (rem >= trial) begin
          rem  <= rem - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 1'b1;
        if (cnt == rbfatc_pkg::STEP_W'(rbfatc_pkg::ROOT_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root[rbfatc_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/rbf_adaptive_torque_controller.sv =====
// ----------------------------------------------------------------------------
// rbf_adaptive_torque_controller
// Adaptive RBF network torque controller for a two-link arm in Q16.16.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one sample: reference
// position, velocity and acceleration and measured position and velocity of
// both links. The output channel (out_valid/out_ready) returns both torques
// and the norm of the network estimates. The configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the eight registers and
// is always ready.
// One request is worked at a time on a single shared 33x33 multiplier and a
// bit-serial square root of 32 steps. The PD-only law skips the norm and the
// node evaluations, and the smooth law adds an exponential evaluation for
// each torque; the next request is accepted from the cycle after the result
// is registered. The fourteen node evaluations dominate the work. The
// fourteen weights live in a small memory with a registered read port and
// are read, updated and written back once per node.
// Reset restores the register defaults and marks all weights as zero.
// While a result waits on a stalled receiver the next request is accepted
// and worked, and it holds in its last step until the output register frees.
// ----------------------------------------------------------------------------
module rbf_adaptive_torque_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ref_pos1,
  input  logic signed [31:0] ref_vel1,
  input  logic signed [31:0] ref_acc1,
  input  logic signed [31:0] ref_pos2,
  input  logic signed [31:0] ref_vel2,
  input  logic signed [31:0] ref_acc2,
  input  logic signed [31:0] meas_pos1,
  input  logic signed [31:0] meas_vel1,
  input  logic signed [31:0] meas_pos2,
  input  logic signed [31:0] meas_vel2,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] drive_torque1,
  output logic signed [31:0] drive_torque2,
  output logic        [30:0] estimate_norm,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic         [2:0] cfg_index,
  input  logic        [30:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_R0, ST_R1, ST_R2, ST_N0, ST_N1, ST_N2, ST_N3, ST_L0, ST_L1,
    ST_D, ST_A, ST_E0, ST_E1, ST_E2, ST_W0, ST_W1, ST_W2, ST_W3, ST_W4,
    ST_T0, ST_T1, ST_T3, ST_T4, ST_F0, ST_F1, ST_F2, ST_F3, ST_OUT
  } state_t;

  state_t st;

  logic [2:0]  law;
  logic [30:0] filter_gain, kv_gain, adapt_step, leak_gain;
  logic [30:0] inv_width_sq, robust_bound, sat_inv_softness;

  logic signed [31:0] rp [2];
  logic signed [31:0] rv [2];
  logic signed [31:0] ra [2];
  logic signed [31:0] mp [2];
  logic signed [31:0] mv [2];
  logic signed [31:0] e  [2];
  logic signed [31:0] ev [2];
  logic signed [31:0] r  [2];
  logic signed [31:0] fest [2];
  logic signed [31:0] tq [2];

  logic [30:0]        rnorm;
  logic signed [31:0] lk1;
  logic [49:0]        dsum;
  logic signed [51:0] acc;
  logic signed [51:0] acc_next;
  logic signed [49:0] tw;
  logic [16:0]        phi;
  logic signed [31:0] term;
  logic [32:0]        yreg;
  logic [63:0]        sq;
  logic [30:0]        fn;
  logic               k;
  logic [rbfatc_pkg::NODE_W-1:0] j;
  logic [2:0]         dcnt;
  logic               ret_torque;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [31:0] mq;

  logic signed [31:0] wmem [2*rbfatc_pkg::NODES];
  logic [2*rbfatc_pkg::NODES-1:0] wvalid;
  logic signed [31:0] wrd_raw;
  logic               wrd_vld;
  logic signed [31:0] wrd;
  logic [rbfatc_pkg::ADDR_W-1:0] addr;

  logic signed [31:0] xsel, dval;
  logic [30:0]        distsat, arg_c;
  logic [32:0]        y_c;
  logic [16:0]        diff_c, val_c;
  logic [16:0]        n_c;
  logic [16:0]        phi_c;
  logic signed [31:0] term_c, wnew, fest_c;
  logic signed [32:0] rabs;
  logic signed [31:0] rk;
  logic               pd, law1, law2, law3;

  rbfatc_pkg::sqrt_req_t sqrt_req;
  rbfatc_pkg::sqrt_rsp_t sqrt_rsp;

  rbfatc_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign pd   = law >= rbfatc_pkg::LAW_PD;
  assign law1 = law == rbfatc_pkg::LAW_LEAK;
  assign law2 = law == rbfatc_pkg::LAW_SMOOTH;
  assign law3 = law == rbfatc_pkg::LAW_SIGN;
  assign in_ready  = st == ST_IDLE;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      law              <= rbfatc_pkg::LAW_SMOOTH;
      filter_gain      <= 31'd327680;
      kv_gain          <= 31'd1966080;
      adapt_step       <= 31'd3277;
      leak_gain        <= 31'd0;
      inv_width_sq     <= 31'd655;
      robust_bound     <= 31'd78643;
      sat_inv_softness <= 31'd131072;
    end else if (cfg_valid) begin
      unique case (rbfatc_pkg::cfg_idx_t'(cfg_index))
        rbfatc_pkg::CFG_LAW:     law              <= cfg_data[2:0];
        rbfatc_pkg::CFG_FILTER:  filter_gain      <= cfg_data;
        rbfatc_pkg::CFG_KV:      kv_gain          <= cfg_data;
        rbfatc_pkg::CFG_ADAPT:   adapt_step       <= cfg_data;
        rbfatc_pkg::CFG_LEAK:    leak_gain        <= cfg_data;
        rbfatc_pkg::CFG_INV_WSQ: inv_width_sq     <= cfg_data;
        rbfatc_pkg::CFG_BOUND:   robust_bound     <= cfg_data;
        rbfatc_pkg::CFG_SOFT:    sat_inv_softness <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      e[i]  = rbfatc_pkg::sat50(50'(rp[i]) - 50'(mp[i]));
      ev[i] = rbfatc_pkg::sat50(50'(rv[i]) - 50'(mv[i]));
    end
  end

  assign rk = r[k];
  assign mq = rbfatc_pkg::sat50($signed(prod[65:16]));
  assign addr = k ? rbfatc_pkg::ADDR_W'(rbfatc_pkg::NODES) + rbfatc_pkg::ADDR_W'(j)
                  : rbfatc_pkg::ADDR_W'(j);
  assign wrd = wrd_vld ? wrd_raw : 32'sd0;

  always_comb begin
    case (dcnt)
      3'd0:    xsel = e[k];
      3'd1:    xsel = ev[k];
      3'd2:    xsel = k ? rp[1] : rp[0];
      3'd3:    xsel = k ? rv[1] : rv[0];
      default: xsel = k ? ra[1] : ra[0];
    endcase
    dval    = rbfatc_pkg::sat50(50'(xsel) - 50'(rbfatc_pkg::center(j)));
    distsat = (dsum > 50'd2147483647) ? 31'h7fffffff : dsum[30:0];
    arg_c   = ($signed(prod[65:16]) > 50'sd2147483647) ? 31'h7fffffff : prod[46:16];
    y_c     = prod[48:16];
    diff_c  = rbfatc_pkg::pow2_tab({1'b0, y_c[15:12]})
            - rbfatc_pkg::pow2_tab({1'b0, y_c[15:12]} + 5'd1);
    val_c   = rbfatc_pkg::pow2_tab({1'b0, yreg[15:12]}) - prod[28:12];
    n_c     = yreg[32:16];
    phi_c   = (n_c >= 17'd32) ? 17'd0 : (val_c >> n_c[4:0]);
    term_c  = law1 ? rbfatc_pkg::sat50(50'(term) - 50'(mq)) : term;
    wnew    = rbfatc_pkg::sat50(50'(wrd) + 50'(mq));
    acc_next = acc + $signed(prod[51:0]);
    fest_c  = rbfatc_pkg::sat50(50'($signed(acc_next[51:16])));
    rabs    = rk[31] ? -33'(rk) : 33'(rk);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st)
      ST_R0: begin mul_a = $signed({2'b0, filter_gain}); mul_b = 33'(e[0]); end
      ST_R1: begin mul_a = $signed({2'b0, filter_gain}); mul_b = 33'(e[1]); end
      ST_N0: begin mul_a = 33'(r[0]); mul_b = 33'(r[0]); end
      ST_N1: begin mul_a = 33'(r[1]); mul_b = 33'(r[1]); end
      ST_L0: begin mul_a = $signed({2'b0, leak_gain}); mul_b = $signed({2'b0, rnorm}); end
      ST_D:  begin mul_a = 33'(dval); mul_b = 33'(dval); end
      ST_A:  begin mul_a = $signed({2'b0, distsat}); mul_b = $signed({2'b0, inv_width_sq}); end
      ST_E0: begin mul_a = $signed({2'b0, arg_c}); mul_b = 33'sd94548; end
      ST_E1: begin mul_a = $signed({16'b0, diff_c}); mul_b = $signed({21'b0, y_c[11:0]}); end
      ST_W0: begin mul_a = $signed({16'b0, phi}); mul_b = 33'(rk); end
      ST_W1: begin mul_a = 33'(lk1); mul_b = 33'(wrd); end
      ST_W2: begin mul_a = $signed({2'b0, adapt_step}); mul_b = 33'(term_c); end
      ST_W3: begin mul_a = 33'(wnew); mul_b = $signed({16'b0, phi}); end
      ST_T0: begin mul_a = $signed({2'b0, kv_gain}); mul_b = 33'(rk); end
      ST_T1: begin mul_a = rabs; mul_b = $signed({2'b0, sat_inv_softness}); end
      ST_T3: begin
        mul_a = $signed({2'b0, robust_bound});
        mul_b = $signed({16'b0, 17'd65536 - phi});
      end
      ST_F0: begin mul_a = 33'(fest[0]); mul_b = 33'(fest[0]); end
      ST_F1: begin mul_a = 33'(fest[1]); mul_b = 33'(fest[1]); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    sqrt_req.start    = (st == ST_N2) || (st == ST_F2);
    sqrt_req.radicand = sq + prod[63:0];
  end

  always_ff @(posedge clk) begin
    if (st == ST_W3) begin
      wmem[addr] <= wnew;
    end
    if (st == ST_D && dcnt == 3'd0) begin
      wrd_raw <= wmem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid <= '0;
    end else begin
      if (st == ST_W3) begin
        wvalid[addr] <= 1'b1;
      end
      if (st == ST_D && dcnt == 3'd0) begin
        wrd_vld <= wvalid[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      k         <= 1'b0;
      j         <= '0;
      dcnt      <= '0;
    end else begin
      if (out_valid && out_ready && (st != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_valid) begin
            rp[0] <= ref_pos1;  rv[0] <= ref_vel1;  ra[0] <= ref_acc1;
            rp[1] <= ref_pos2;  rv[1] <= ref_vel2;  ra[1] <= ref_acc2;
            mp[0] <= meas_pos1; mv[0] <= meas_vel1;
            mp[1] <= meas_pos2; mv[1] <= meas_vel2;
            st <= ST_R0;
          end
        end
        ST_R0: st <= ST_R1;
        ST_R1: begin
          r[0] <= rbfatc_pkg::sat50(50'(ev[0]) + 50'(mq));
          st   <= ST_R2;
        end
        ST_R2: begin
          r[1] <= rbfatc_pkg::sat50(50'(ev[1]) + 50'(mq));
          k    <= 1'b0;
          j    <= '0;
          dcnt <= '0;
          acc  <= '0;
          if (pd) begin
            fest[0] <= 32'sd0;
            fest[1] <= 32'sd0;
            st      <= ST_T0;
          end else begin
            st <= ST_N0;
          end
        end
        ST_N0: st <= ST_N1;
        ST_N1: begin
          sq <= prod[63:0];
          st <= ST_N2;
        end
        ST_N2: st <= ST_N3;
        ST_N3: begin
          if (sqrt_rsp.done) begin
            rnorm <= sqrt_rsp.root[31] ? 31'h7fffffff : sqrt_rsp.root[30:0];
            st    <= ST_L0;
          end
        end
        ST_L0: st <= ST_L1;
        ST_L1: begin
          lk1 <= mq;
          st  <= ST_D;
        end
        ST_D: begin
          if (dcnt == 3'd0) begin
            dsum <= '0;
          end else begin
            dsum <= dsum + 50'(prod[62:16]);
          end
          if (dcnt == 3'd5) begin
            dcnt <= '0;
            st   <= ST_A;
          end else begin
            dcnt <= dcnt + 3'd1;
          end
        end
        ST_A: begin
          ret_torque <= 1'b0;
          st         <= ST_E0;
        end
        ST_E0: st <= ST_E1;
        ST_E1: begin
          yreg <= y_c;
          st   <= ST_E2;
        end
        ST_E2: begin
          phi <= phi_c;
          st  <= ret_torque ? ST_T3 : ST_W0;
        end
        ST_W0: st <= ST_W1;
        ST_W1: begin
          term <= mq;
          st   <= ST_W2;
        end
        ST_W2: st <= ST_W3;
        ST_W3: st <= ST_W4;
        ST_W4: begin
          if (j == rbfatc_pkg::NODE_W'(rbfatc_pkg::NODES - 1)) begin
            fest[k] <= fest_c;
            acc     <= '0;
            j       <= '0;
            if (k) begin
              k  <= 1'b0;
              st <= ST_T0;
            end else begin
              k  <= 1'b1;
              st <= ST_D;
            end
          end else begin
            acc <= acc_next;
            j   <= j + 1'b1;
            st  <= ST_D;
          end
        end
        ST_T0: st <= ST_T1;
        ST_T1: begin
          tw <= 50'(fest[k]) + 50'(mq);
          if (law2) begin
            ret_torque <= 1'b1;
            st         <= ST_E0;
          end else begin
            st <= ST_T4;
          end
        end
        ST_T3: st <= ST_T4;
        ST_T4: begin
          if (law2) begin
            tq[k] <= rbfatc_pkg::sat50(rk[31] ? tw - 50'(mq) : tw + 50'(mq));
          end else if (law3) begin
            tq[k] <= rbfatc_pkg::sat50(rk[31] ? tw - 50'(robust_bound)
                                              : tw + 50'(robust_bound));
          end else begin
            tq[k] <= rbfatc_pkg::sat50(tw);
          end
          if (k) begin
            k  <= 1'b0;
            st <= ST_F0;
          end else begin
            k  <= 1'b1;
            st <= ST_T0;
          end
        end
        ST_F0: st <= ST_F1;
        ST_F1: begin
          sq <= prod[63:0];
          st <= ST_F2;
        end
        ST_F2: st <= ST_F3;
        ST_F3: begin
          if (sqrt_rsp.done) begin
            fn <= sqrt_rsp.root[31] ? 31'h7fffffff : sqrt_rsp.root[30:0];
            st <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            drive_torque1 <= tq[0];
            drive_torque2 <= tq[1];
            estimate_norm <= fn;
            out_valid     <= 1'b1;
            st            <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: two-link RBF adaptive torque controller testbench
// This bench sends samples through the valid/ready input channel. A built-in
// model of the controller predicts each torque pair and estimate norm. That
// model keeps its own copy of the node weights and registers. A checker
// compares every returned result with the oldest prediction. The stimulus
// covers all control laws, the register extremes, field extremes, and random
// samples. Random idling is applied on both channels.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic signed [31:0] tq1;
    logic signed [31:0] tq2;
    logic [30:0]        enorm;
  } torque_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] ref_pos1 = '0, ref_vel1 = '0, ref_acc1 = '0;
  logic signed [31:0] ref_pos2 = '0, ref_vel2 = '0, ref_acc2 = '0;
  logic signed [31:0] meas_pos1 = '0, meas_vel1 = '0, meas_pos2 = '0, meas_vel2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] drive_torque1, drive_torque2;
  logic [30:0] estimate_norm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  rbf_adaptive_torque_controller dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint cfg_model[8];
  longint weights[2 * rbfatc_pkg::NODES];
  torque_result_t expected_q[$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  localparam longint MAXQ = 64'sd2147483647;
  localparam longint MINQ = -64'sd2147483648;

  function automatic longint sat(longint x);
    if (x > MAXQ) return MAXQ;
    if (x < MINQ) return MINQ;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned rem, root, bitv;
    rem = v;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic longint vec_norm(longint a, longint b);
    longint unsigned s, q;
    s = longint'(a * a) + longint'(b * b);
    q = root_floor(s);
    return (q > MAXQ) ? MAXQ : longint'(q);
  endfunction

  function automatic longint exp_decay(longint a);
    longint lut[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                        46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219,
                        32768};
    longint y, n, f, idx, rem, val;
    y = (a * 94548) >>> 16;
    n = y >>> 16;
    f = y & 64'hFFFF;
    idx = f >>> 12;
    rem = f & 64'hFFF;
    if (n >= 32) return 0;
    val = lut[idx] - (((lut[idx] - lut[idx + 1]) * rem) >>> 12);
    return val >>> n;
  endfunction

  function automatic longint node_activation(longint x[5], int j);
    longint c, dsum, d, arg;
    c = (longint'(2 * j - rbfatc_pkg::NODES + 1) * rbfatc_pkg::CENTER_STEP_Q16) >>> 1;
    dsum = 0;
    for (int v = 0; v < 5; v++) begin
      d = sat(x[v] - c);
      dsum += (d * d) >>> 16;
    end
    if (dsum > MAXQ) dsum = MAXQ;
    arg = (dsum * cfg_model[rbfatc_pkg::CFG_INV_WSQ]) >>> 16;
    if (arg > MAXQ) arg = MAXQ;
    return exp_decay(arg);
  endfunction

  function automatic torque_result_t predict_torques(longint s[10]);
    torque_result_t res;
    longint x[2][5], r[2], fest[2], tq[2], rn, acc, phi, term, lk, t, mag, a, v;
    longint law;
    bit pd;
    law = cfg_model[rbfatc_pkg::CFG_LAW];
    pd = law >= rbfatc_pkg::LAW_PD;
    for (int k = 0; k < 2; k++) begin
      x[k][0] = sat(s[3 * k] - s[6 + 2 * k]);
      x[k][1] = sat(s[3 * k + 1] - s[7 + 2 * k]);
      x[k][2] = s[3 * k];
      x[k][3] = s[3 * k + 1];
      x[k][4] = s[3 * k + 2];
      r[k] = sat(x[k][1] + qmul(cfg_model[rbfatc_pkg::CFG_FILTER], x[k][0]));
    end
    rn = vec_norm(r[0], r[1]);
    for (int k = 0; k < 2; k++) begin
      acc = 0;
      for (int j = 0; j < rbfatc_pkg::NODES; j++) begin
        phi = node_activation(x[k], j);
        if (!pd) begin
          term = qmul(phi, r[k]);
          if (law == rbfatc_pkg::LAW_LEAK) begin
            lk = qmul(qmul(cfg_model[rbfatc_pkg::CFG_LEAK], rn),
                      weights[k * rbfatc_pkg::NODES + j]);
            term = sat(term - lk);
          end
          weights[k * rbfatc_pkg::NODES + j] =
            sat(weights[k * rbfatc_pkg::NODES + j] +
                qmul(cfg_model[rbfatc_pkg::CFG_ADAPT], term));
        end
        acc += weights[k * rbfatc_pkg::NODES + j] * phi;
      end
      fest[k] = pd ? 0 : sat(acc >>> 16);
    end
    for (int k = 0; k < 2; k++) begin
      t = fest[k] + qmul(cfg_model[rbfatc_pkg::CFG_KV], r[k]);
      if (law == rbfatc_pkg::LAW_SMOOTH) begin
        mag = (r[k] < 0) ? -r[k] : r[k];
        a = (mag * cfg_model[rbfatc_pkg::CFG_SOFT]) >>> 16;
        if (a > MAXQ) a = MAXQ;
        v = qmul(cfg_model[rbfatc_pkg::CFG_BOUND], 65536 - exp_decay(a));
        t += (r[k] >= 0) ? v : -v;
      end else if (law == rbfatc_pkg::LAW_SIGN) begin
        t += (r[k] >= 0) ? cfg_model[rbfatc_pkg::CFG_BOUND]
                         : -cfg_model[rbfatc_pkg::CFG_BOUND];
      end
      tq[k] = sat(t);
    end
    res.tq1 = tq[0][31:0];
    res.tq2 = tq[1][31:0];
    res.enorm = 31'(vec_norm(fest[0], fest[1]));
    return res;
  endfunction

  // Result checker: sampled at the falling edge, accepted at the next rising edge.
  always @(negedge clk) begin
    torque_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result t1=%0d t2=%0d norm=%0d", $time,
                 drive_torque1, drive_torque2, estimate_norm);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (drive_torque1 !== exp_r.tq1) begin
          $display("%0t: drive_torque1 expected %0d actual %0d", $time, exp_r.tq1,
                   drive_torque1);
          errors++;
        end
        if (drive_torque2 !== exp_r.tq2) begin
          $display("%0t: drive_torque2 expected %0d actual %0d", $time, exp_r.tq2,
                   drive_torque2);
          errors++;
        end
        if (estimate_norm !== exp_r.enorm) begin
          $display("%0t: estimate_norm expected %0d actual %0d", $time, exp_r.enorm,
                   estimate_norm);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
  end

  task automatic send_sample(input longint s[10]);
    bit rdy;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    ref_pos1 <= s[0][31:0]; ref_vel1 <= s[1][31:0]; ref_acc1 <= s[2][31:0];
    ref_pos2 <= s[3][31:0]; ref_vel2 <= s[4][31:0]; ref_acc2 <= s[5][31:0];
    meas_pos1 <= s[6][31:0]; meas_vel1 <= s[7][31:0];
    meas_pos2 <= s[8][31:0]; meas_vel2 <= s[9][31:0];
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    expected_q.push_back(predict_torques(s));
    samples_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // Registers change only while no request is in flight.
  task automatic write_reg(input rbfatc_pkg::cfg_idx_t idx, input longint val);
    bit rdy;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[30:0];
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    cfg_model[idx] = (idx == rbfatc_pkg::CFG_LAW) ? (val & 7) : (val & MAXQ);
    cfg_writes++;
  endtask

  function automatic longint rand_field(int spread);
    case (spread)
      0: return longint'($urandom_range(262143)) - 131072;
      1: return longint'($urandom_range(2097151)) - 1048576;
      default: return longint'(signed'(32'($urandom)));
    endcase
  endfunction

  task automatic send_random(int n, int wide_pct);
    longint s[10];
    for (int i = 0; i < n; i++) begin
      for (int f = 0; f < 10; f++) begin
        s[f] = rand_field(($urandom_range(99) < wide_pct) ? 2 :
                          int'($urandom_range(1)));
      end
      send_sample(s);
    end
  endtask

  task automatic test_directed();
    longint s[10];
    longint edges[4] = '{MAXQ, MINQ, 0, -1};
    for (rbfatc_pkg::cfg_idx_t l = rbfatc_pkg::CFG_LAW; ;
         l = rbfatc_pkg::cfg_idx_t'(l + 1)) begin
      write_reg(rbfatc_pkg::CFG_LAW, l);
      s = '{default: 0};
      send_sample(s);
      s = '{65536, 32768, -98304, -65536, 0, 16384, 0, -32768, -131072, 65536};
      send_sample(s);
      s = '{0, -65536, 0, 0, 65536, 0, 65536, 0, -65536, 131072};
      send_sample(s);
      if (l == rbfatc_pkg::CFG_SOFT) break;
    end
    wait_drained();
    for (int e = 0; e < 4; e++) begin
      s = '{default: edges[e]};
      send_sample(s);
      for (int f = 6; f < 10; f++) s[f] = edges[3 - e];
      send_sample(s);
    end
    wait_drained();
  endtask

  task automatic test_law_phases();
    longint law_seq[8] = '{rbfatc_pkg::LAW_PLAIN, rbfatc_pkg::LAW_LEAK,
                           rbfatc_pkg::LAW_SMOOTH, rbfatc_pkg::LAW_SIGN,
                           rbfatc_pkg::LAW_PD, rbfatc_pkg::LAW_LEAK, 5,
                           rbfatc_pkg::LAW_SMOOTH};
    for (int p = 0; p < 8; p++) begin
      write_reg(rbfatc_pkg::CFG_LAW, law_seq[p]);
      write_reg(rbfatc_pkg::CFG_LEAK, (p == 5) ? 1311 : $urandom_range(65536));
      write_reg(rbfatc_pkg::CFG_ADAPT, $urandom_range(3277, 65536));
      write_reg(rbfatc_pkg::CFG_INV_WSQ, $urandom_range(65536));
      write_reg(rbfatc_pkg::CFG_SOFT, $urandom_range(1, 262144));
      tx_idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 45 : 25) : 0;
      rx_stall_pct = (p % 4 == 2) ? 45 : ((p % 4 == 3) ? 25 : 0);
      send_random(45, 10);
      if (p == 3) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
      end
      send_random(45, 10);
      wait_drained();
    end
  endtask

  task automatic test_register_extremes();
    rbfatc_pkg::cfg_idx_t idx;
    for (int p = 0; p < 3; p++) begin
      for (int i = 1; i < 8; i++) begin
        idx = rbfatc_pkg::cfg_idx_t'(i);
        write_reg(idx, (p == 0) ? MAXQ : ((p == 1) ? 0 : $urandom));
      end
      write_reg(rbfatc_pkg::CFG_LAW, (p == 0) ? rbfatc_pkg::LAW_LEAK :
                ((p == 1) ? 7 : rbfatc_pkg::LAW_SMOOTH));
      tx_idle_pct = 25;
      rx_stall_pct = 25;
      send_random(25, 50);
      wait_drained();
    end
    write_reg(rbfatc_pkg::CFG_FILTER, 327680);
    write_reg(rbfatc_pkg::CFG_KV, 1966080);
    write_reg(rbfatc_pkg::CFG_ADAPT, 3277);
    write_reg(rbfatc_pkg::CFG_LEAK, 0);
    write_reg(rbfatc_pkg::CFG_INV_WSQ, 655);
    write_reg(rbfatc_pkg::CFG_BOUND, 78643);
    write_reg(rbfatc_pkg::CFG_SOFT, 131072);
    write_reg(rbfatc_pkg::CFG_LAW, rbfatc_pkg::LAW_SIGN);
    send_random(25, 5);
    wait_drained();
  endtask

  initial begin
    cfg_model = '{2, 327680, 1966080, 3277, 0, 655, 78643, 131072};
    weights = '{default: 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_law_phases();
    test_register_extremes();
    wait_drained();
    $display("Sent %0d samples, checked %0d results, %0d register writes.",
             samples_sent, results_seen, cfg_writes);
    $display("Covered all control laws, unused law codes, register extremes and idling.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

endmodule
